// ===== rtl/core/signed_restoring_divider_top_defines.svh =====
// Assertion macros shared by the divider checker.
`ifndef SIGNED_RESTORING_DIVIDER_TOP_DEFINES_SVH
`define SIGNED_RESTORING_DIVIDER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SDIV_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define SDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sdiv_pkg.sv =====
// Shared widths and pipeline payload type of the signed restoring divider.
`default_nettype none
package sdiv_pkg;

	// Number of restoring steps and quotient register width
	localparam int WIDTH  = 16;
	// Operand width of dividend and divisor
	localparam int DIN_W  = 16;
	// Operand magnitude width (the most negative operand still fits unsigned)
	localparam int MAG_W  = DIN_W;
	// Result field widths
	localparam int QUOT_W = 17;
	localparam int REM_W  = 16;

	// Payload carried from stage to stage
	typedef struct packed {
		logic [MAG_W-1:0] acc;
		logic [WIDTH-1:0] qmag;
		logic [MAG_W-1:0] mmag;
		logic             neg_q;
		logic             neg_r;
		logic             dbz;
	} stage_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdiv_in_if.sv =====
// Operand channel: valid/ready handshake carrying dividend and divisor.
`default_nettype none
interface sdiv_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [sdiv_pkg::DIN_W-1:0]   dividend;
	logic signed [sdiv_pkg::DIN_W-1:0]   divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sdiv_out_if.sv =====
// Result channel: valid/ready handshake carrying quotient, remainder and error flag.
`default_nettype none
interface sdiv_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [sdiv_pkg::QUOT_W-1:0]  quotient;
	logic signed [sdiv_pkg::REM_W-1:0]   remainder;
	logic                                divide_by_zero;

	modport source (output valid, output quotient, output remainder,
		output divide_by_zero, input ready);
	modport sink   (input valid, input quotient, input remainder,
		input divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sdiv_prep.sv =====
// Entry stage: record signs, take operand magnitudes, clear the partial remainder.
`default_nettype none
module sdiv_prep (
	input  wire logic          clk,
	input  wire logic          arst_n,
	sdiv_in_if.sink            req,
	output logic               out_valid,
	input  wire logic          out_ready,
	output sdiv_pkg::stage_t   out_data
);
	import sdiv_pkg::*;

	logic [DIN_W-1:0] dvd;
	logic [DIN_W-1:0] dvs;
	logic             dvd_neg;
	logic             dvs_neg;
	logic             dvd_pos;
	logic             dvs_pos;
	logic [MAG_W-1:0] dvd_mag;
	logic [MAG_W-1:0] dvs_mag;
	stage_t           nxt;
	logic             valid_s1;
	stage_t           data_s1;

	// Decode signs and magnitudes
	always_comb begin
		dvd     = req.dividend;
		dvs     = req.divisor;
		dvd_neg = dvd[DIN_W-1];
		dvs_neg = dvs[DIN_W-1];
		dvd_pos = !dvd_neg && (dvd != '0);
		dvs_pos = !dvs_neg && (dvs != '0);
		dvd_mag = dvd_neg ? MAG_W'(~dvd + 1'b1) : MAG_W'(dvd);
		dvs_mag = dvs_neg ? MAG_W'(~dvs + 1'b1) : MAG_W'(dvs);

		nxt       = '0;
		nxt.acc   = '0;
		nxt.qmag  = WIDTH'(dvd_mag);
		nxt.mmag  = dvs_mag;
		nxt.neg_q = (dvd_neg && dvs_pos) || (dvd_pos && dvs_neg);
		nxt.neg_r = dvd_neg;
		nxt.dbz   = (dvs == '0);
	end

	// Accept when the stage is empty or its content moves on
	assign req.ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Load payload on each transaction
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
endmodule
`default_nettype wire

// ===== rtl/core/sdiv_stage.sv =====
// One restoring step: shift, trial subtract, restore or set the quotient bit.
`default_nettype none
module sdiv_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sdiv_pkg::stage_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sdiv_pkg::stage_t       out_data
);
	import sdiv_pkg::*;

	logic [MAG_W:0] acc_sh;
	logic [MAG_W:0] diff;
	logic           ge;
	stage_t         nxt;
	logic           valid_s1;
	stage_t         data_s1;

	// Shift the remainder/quotient pair and try the subtraction
	always_comb begin
		acc_sh   = {in_data.acc, in_data.qmag[WIDTH-1]};
		diff     = acc_sh - {1'b0, in_data.mmag};
		ge       = (acc_sh >= {1'b0, in_data.mmag});
		nxt      = in_data;
		nxt.acc  = ge ? diff[MAG_W-1:0] : acc_sh[MAG_W-1:0];
		nxt.qmag = {in_data.qmag[WIDTH-2:0], ge};
	end

	// Advance when empty or when the next stage takes the content
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
endmodule
`default_nettype wire

// ===== rtl/core/sdiv_fix.sv =====
// Exit stage: apply quotient and remainder signs, zero results on divide by zero.
`default_nettype none
module sdiv_fix (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sdiv_pkg::stage_t  in_data,
	sdiv_out_if.source             rsp
);
	import sdiv_pkg::*;

	logic [QUOT_W-1:0] q_ext;
	logic [REM_W-1:0]  r_ext;
	logic [QUOT_W-1:0] quot_nxt;
	logic [REM_W-1:0]  rem_nxt;
	logic              valid_s1;
	logic [QUOT_W-1:0] quot_s1;
	logic [REM_W-1:0]  rem_s1;
	logic              dbz_s1;

	// Negate magnitudes as the signs demand
	always_comb begin
		q_ext    = QUOT_W'(in_data.qmag);
		r_ext    = REM_W'(in_data.acc);
		quot_nxt = in_data.neg_q ? (~q_ext + 1'b1) : q_ext;
		rem_nxt  = in_data.neg_r ? (~r_ext + 1'b1) : r_ext;
		if (in_data.dbz) begin
			quot_nxt = '0;
			rem_nxt  = '0;
		end
	end

	// Output register: refill when empty or when the result is taken
	assign in_ready = !valid_s1 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			quot_s1 <= quot_nxt;
			rem_s1  <= rem_nxt;
			dbz_s1  <= in_data.dbz;
		end
	end

	assign rsp.valid          = valid_s1;
	assign rsp.quotient       = quot_s1;
	assign rsp.remainder      = rem_s1;
	assign rsp.divide_by_zero = dbz_s1;
endmodule
`default_nettype wire

// ===== rtl/core/signed_restoring_divider_top.sv =====
// Signed restoring divider: entry stage, one stage per quotient bit, sign-fix stage.
// Throughput: one operand pair per cycle; each stage holds one item and stalls only
// when it is full and the stage after it cannot take its content.
// Reset: arst_n low clears all stage valid bits at once; payload registers keep values.
`default_nettype none
module signed_restoring_divider_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sdiv_in_if.sink    req,
	sdiv_out_if.source rsp
);
	import sdiv_pkg::*;

	logic   pipe_valid [WIDTH+1];
	logic   pipe_ready [WIDTH+1];
	stage_t pipe_data  [WIDTH+1];

	// Record signs and magnitudes
	sdiv_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_valid (pipe_valid[0]),
		.out_ready (pipe_ready[0]),
		.out_data  (pipe_data[0])
	);

	// One restoring step per quotient bit
	for (genvar k = 0; k < WIDTH; k++) begin : g_step
		sdiv_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pipe_valid[k]),
			.in_ready  (pipe_ready[k]),
			.in_data   (pipe_data[k]),
			.out_valid (pipe_valid[k+1]),
			.out_ready (pipe_ready[k+1]),
			.out_data  (pipe_data[k+1])
		);
	end

	// Apply signs and drive the result channel
	sdiv_fix u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pipe_valid[WIDTH]),
		.in_ready (pipe_ready[WIDTH]),
		.in_data  (pipe_data[WIDTH]),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire

// ===== rtl/core/sdiv_checker.sv =====
// Port-level checker for the signed restoring divider, bound to the top level.
`default_nettype none
`include "signed_restoring_divider_top_defines.svh"
module sdiv_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_ready,
	input wire logic signed [sdiv_pkg::QUOT_W-1:0] rsp_quotient,
	input wire logic signed [sdiv_pkg::REM_W-1:0]  rsp_remainder,
	input wire logic                               rsp_divide_by_zero
);
	import sdiv_pkg::*;

	logic [QUOT_W-1:0] quot_u;
	logic [REM_W-1:0]  rem_u;
	logic              quot_over;
	logic              rem_over;

	// Range limits of the result fields
	always_comb begin
		quot_u    = rsp_quotient;
		rem_u     = rsp_remainder;
		quot_over = !quot_u[QUOT_W-1] && quot_u[QUOT_W-2] && (quot_u[QUOT_W-3:0] != '0);
		rem_over  = rem_u[REM_W-1] && (rem_u[REM_W-2:0] == '0);
	end

	// Hold a stalled result
	`SDIV_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`SDIV_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_quotient) && $stable(rsp_remainder) && $stable(rsp_divide_by_zero), "stalled result changed")

	// Divide by zero gives zero results
	`SDIV_ASSERT_ALWAYS(a_dbz_zero, clk, arst_n, !(rsp_valid && rsp_divide_by_zero) || (rsp_quotient == '0 && rsp_remainder == '0), "nonzero result on divide by zero")

	// Quotient and remainder stay within their magnitude limits
	`SDIV_ASSERT_ALWAYS(a_range, clk, arst_n, !rsp_valid || (!quot_over && !rem_over), "result out of range")
endmodule

bind signed_restoring_divider_top sdiv_checker u_sdiv_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_quotient       (rsp.quotient),
	.rsp_remainder      (rsp.remainder),
	.rsp_divide_by_zero (rsp.divide_by_zero)
);
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the signed restoring divider: operand stimulus, result predictor and checks.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import sdiv_pkg::*;

	localparam int RANDOM_PAIRS = 1700;
	localparam int DRAIN_CYCLES = WIDTH + 12;

	typedef struct {
		logic signed [QUOT_W-1:0] quotient;
		logic signed [REM_W-1:0]  remainder;
		logic                     divide_by_zero;
	} division_t;

	// Quotient/remainder predictor and the in-order queue of predicted results
	class division_ledger;
		division_t pending_results[$];
		int        failures;
		int        results_seen;

		// Run the signed-magnitude restoring division on one operand pair
		function division_t divide_restoring(logic signed [DIN_W-1:0] num,
				logic signed [DIN_W-1:0] den);
			logic [MAG_W:0]      rem_acc;
			logic [MAG_W:0]      den_mag;
			logic [MAG_W:0]      num_mag;
			logic [WIDTH-1:0]    quo_mag;
			logic [QUOT_W-1:0]   quo;
			logic [REM_W-1:0]    rem;
			logic                neg_quo;
			logic                neg_rem;
			int                  num_int;
			int                  den_int;
			division_t           res;
			num_int = num;
			den_int = den;
			if (den_int == 0) begin
				res.quotient = '0;
				res.remainder = '0;
				res.divide_by_zero = 1'b1;
				return res;
			end
			neg_quo = (num_int < 0 && den_int > 0) || (num_int > 0 && den_int < 0);
			neg_rem = num_int < 0;
			num_mag = (MAG_W+1)'((num_int < 0) ? -num_int : num_int);
			den_mag = (MAG_W+1)'((den_int < 0) ? -den_int : den_int);
			// Keep only the bits the quotient register can hold
			quo_mag = num_mag[WIDTH-1:0];
			rem_acc = '0;
			for (int step = 0; step < WIDTH; step++) begin
				rem_acc = {rem_acc[MAG_W-1:0], quo_mag[WIDTH-1]};
				quo_mag = quo_mag << 1;
				if (rem_acc >= den_mag) begin
					rem_acc = rem_acc - den_mag;
					quo_mag[0] = 1'b1;
				end
			end
			quo = QUOT_W'(quo_mag);
			rem = rem_acc[REM_W-1:0];
			if (neg_quo)
				quo = -quo;
			if (neg_rem)
				rem = -rem;
			res.quotient = quo;
			res.remainder = rem;
			res.divide_by_zero = 1'b0;
			return res;
		endfunction

		// Predict the result of an accepted operand transaction
		function void note_operands(logic signed [DIN_W-1:0] num,
				logic signed [DIN_W-1:0] den);
			pending_results.push_back(divide_restoring(num, den));
		endfunction

		// Compare a result transaction against the oldest prediction
		function void check_result(division_t got);
			division_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result %0d arrived with no prediction: %s",
						results_seen,
						$sformatf("q=%0d r=%0d dbz=%0b",
							got.quotient, got.remainder, got.divide_by_zero));
				return;
			end
			want = pending_results.pop_front();
			if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
					got.divide_by_zero !== want.divide_by_zero) begin
				failures++;
				if (failures <= 10)
					$display("result %0d mismatch: expected %s, got %s",
						results_seen,
						$sformatf("q=%0d r=%0d dbz=%0b",
							want.quotient, want.remainder, want.divide_by_zero),
						$sformatf("q=%0d r=%0d dbz=%0b",
							got.quotient, got.remainder, got.divide_by_zero));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	longint unsigned cycle_count = 0;

	sdiv_in_if  operands();
	sdiv_out_if results();

	division_ledger ledger = new();

	signed_restoring_divider_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (operands),
		.rsp    (results)
	);

	// Toggle the 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Pick an idle stretch: mostly none or short, occasionally long
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one operand transaction; called and returning at a falling edge
	task automatic send_operands(input logic signed [DIN_W-1:0] num,
			input logic signed [DIN_W-1:0] den, input bit calm);
		int gap;
		gap = calm ? 0 : idle_length();
		if (gap > 0) begin
			operands.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operands.valid <= 1'b1;
		operands.dividend <= num;
		operands.divisor <= den;
		do
			@(posedge clk);
		while (!operands.ready);
		ledger.note_operands(num, den);
		@(negedge clk);
	endtask

	// Draw an operand pair weighted toward the interesting corners
	task automatic random_operands(output logic signed [DIN_W-1:0] num,
			output logic signed [DIN_W-1:0] den);
		int roll;
		roll = $urandom_range(0, 99);
		num = DIN_W'($urandom());
		den = DIN_W'($urandom());
		if (roll < 8) begin
			den = '0;
		end else if (roll < 22) begin
			den = DIN_W'($urandom_range(1, 15));
			if ($urandom_range(0, 1))
				den = -den;
		end else if (roll < 28) begin
			case ($urandom_range(0, 3))
				0: den = 16'sh8000;
				1: den = 16'sh7fff;
				2: den = 16'sh0001;
				default: den = 16'shffff;
			endcase
		end else if (roll < 34) begin
			num = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
		end else if (roll < 40) begin
			num = DIN_W'($urandom_range(0, 63));
			if ($urandom_range(0, 1))
				num = -num;
		end
	endtask

	// Throttle result acceptance with random stalls, calm every fourth stretch
	initial begin
		int stall_left;
		stall_left = 0;
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				results.ready <= 1'b0;
				stall_left--;
			end else if ((cycle_count / 1000) % 4 == 0 || $urandom_range(0, 99) < 80) begin
				results.ready <= 1'b1;
			end else begin
				results.ready <= 1'b0;
				stall_left = idle_length();
			end
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		division_t got;
		if (arst_n && results.valid && results.ready) begin
			got.quotient = results.quotient;
			got.remainder = results.remainder;
			got.divide_by_zero = results.divide_by_zero;
			ledger.check_result(got);
		end
	end

	// Directed corners, then random pairs, then drain
	initial begin
		logic signed [DIN_W-1:0] directed_num[$];
		logic signed [DIN_W-1:0] directed_den[$];
		logic signed [DIN_W-1:0] num;
		logic signed [DIN_W-1:0] den;
		arst_n = 1'b0;
		operands.valid = 1'b0;
		operands.dividend = '0;
		operands.divisor = '0;
		directed_num = '{16'sh7fff, -16'sd32768, -16'sd32768, -16'sd32768, 16'sh7fff,
			-16'sd32768, 16'sd0, 16'sd0, 16'sd7, -16'sd32768, 16'sd0, 16'sd7,
			-16'sd7, 16'sd7, -16'sd7, 16'sd1, -16'sd1, 16'sh7fff, 16'sd5,
			-16'sd32768, 16'sd100, -16'sd100, 16'sd12345, -16'sd1};
		directed_den = '{16'sd1, 16'sd1, -16'sd1, 16'sh7fff, -16'sd32768,
			-16'sd32768, 16'sd5, -16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd2,
			16'sd2, -16'sd2, -16'sd2, 16'sh7fff, -16'sd32768, 16'sh7fff,
			-16'sd32768, 16'sd2, 16'sd7, -16'sd7, -16'sd1, 16'sd1};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_num[idx])
			send_operands(directed_num[idx], directed_den[idx], idx < 8);

		for (int item = 0; item < RANDOM_PAIRS; item++) begin
			random_operands(num, den);
			send_operands(num, den, (item / 128) % 4 == 1);
		end
		operands.valid <= 1'b0;

		// Drain the pipeline and catch any stray results
		while (ledger.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.pending_results.size() != 0) begin
			ledger.failures++;
			$display("%0d predicted results never arrived", ledger.pending_results.size());
		end

		if (ledger.failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
